### hdl/torus_grid_vertex_generator_defines.svh
// Assertion helpers for the vertex generator RTL.
`ifndef TORUS_GRID_VERTEX_GENERATOR_DEFINES_SVH
`define TORUS_GRID_VERTEX_GENERATOR_DEFINES_SVH

// Checked only while out of reset.
`define TGV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define TGV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/tgv_pkg.sv
package tgv_pkg;

  localparam int unsigned MAX_SEGMENTS = 256;
  localparam int unsigned ANGLE_BITS   = 16;

  localparam int unsigned CNT_W  = 9;
  localparam int unsigned RAD_W  = 16;
  localparam int unsigned IDX_W  = 17;
  localparam int unsigned POS_W  = 18;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned TEX_W  = 17;
  localparam int unsigned REM_W  = CNT_W + ANGLE_BITS;
  localparam int unsigned QUO_W  = ANGLE_BITS + 1;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [RAD_W-1:0] MAJOR_RADIUS_RST = RAD_W'(256);
  localparam logic [RAD_W-1:0] MINOR_RADIUS_RST = RAD_W'(64);
  localparam logic [CNT_W-1:0] MAJOR_COUNT_RST  = CNT_W'(32);
  localparam logic [CNT_W-1:0] MINOR_COUNT_RST  = CNT_W'(16);

  // pipeline layout
  localparam int unsigned DIV_CELLS   = QUO_W;
  localparam int unsigned ST_TRIG     = DIV_CELLS + 1;
  localparam int unsigned TRIG_STAGES = 11;
  localparam int unsigned ST_VTX      = ST_TRIG + TRIG_STAGES;
  localparam int unsigned VTX_STAGES  = 3;
  localparam int unsigned N_STAGES    = ST_VTX + VTX_STAGES;

  // pi/2 in Q32
  localparam logic [32:0] PI_HALF_Q32 = 33'd6746518852;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // floor(v/d) for v < 2^31 as (v*MAG) >> SH, MAG = ceil(2^SH/d)
  // row 0: sine series divisors 72 42 20 6, row 1: cosine 90 56 30 12
  localparam logic [31:0] DIV_MAG [2][4] = '{
    '{32'(((64'd1 << 38) + 64'd71) / 64'd72), 32'(((64'd1 << 37) + 64'd41) / 64'd42),
      32'(((64'd1 << 36) + 64'd19) / 64'd20), 32'(((64'd1 << 34) + 64'd5) / 64'd6)},
    '{32'(((64'd1 << 38) + 64'd89) / 64'd90), 32'(((64'd1 << 37) + 64'd55) / 64'd56),
      32'(((64'd1 << 36) + 64'd29) / 64'd30), 32'(((64'd1 << 35) + 64'd11) / 64'd12)}
  };
  localparam int unsigned DIV_SH [2][4] = '{'{38, 37, 36, 34}, '{38, 37, 36, 35}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAJOR_RADIUS,
    CFG_MINOR_RADIUS,
    CFG_MAJOR_COUNT,
    CFG_MINOR_COUNT
  } cfg_reg_e;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
  } vtx_t;

  typedef struct packed {
    logic             ok;
    logic             qs;
    logic [IDX_W-1:0] vi;
    logic [IDX_W-1:0] rbi;
    logic [TEX_W-1:0] tu;
    logic [TEX_W-1:0] tv;
  } side_t;

  // Q30 multiply, rounded
  function automatic logic [30:0] mulq30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] p;
    p = 62'(a) * 62'(b) + 62'(1) * 62'(Q30_ONE >> 1);
    return 31'(p >> 30);
  endfunction

endpackage

### hdl/tgv_if.sv
interface tgv_in_if;
  import tgv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] ring_step;
  logic [CNT_W-1:0] tube_step;
  modport source (output valid, ring_step, tube_step, input ready);
  modport sink (input valid, ring_step, tube_step, output ready);
endinterface

interface tgv_out_if;
  import tgv_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic signed [NRM_W-1:0] norm_x;
  logic signed [NRM_W-1:0] norm_y;
  logic signed [NRM_W-1:0] norm_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic [IDX_W-1:0]        vertex_index;
  logic [IDX_W-1:0]        row_below_index;
  logic                    quad_start;
  logic                    point_valid;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  vertex_index, row_below_index, quad_start, point_valid, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                vertex_index, row_below_index, quad_start, point_valid, output ready);
endinterface

interface tgv_cfg_if;
  import tgv_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/tgv_div_cell.sv
// One quotient bit per cell for each of the two lanes (restoring divide).
module tgv_div_cell (
  input  logic                                  clk_i,
  input  logic                                  adv_i,
  input  logic [1:0][tgv_pkg::CNT_W-1:0]        dvs_i,
  input  tgv_pkg::div_lane_t [1:0]              lane_i,
  output tgv_pkg::div_lane_t [1:0]              lane_o
);
  import tgv_pkg::*;

  div_lane_t [1:0] lane_d, lane_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] nrem;
      trial = {1'b0, lane_i[l].rem} - {1'b0, dvs_i[l], {ANGLE_BITS{1'b0}}};
      nrem  = trial[REM_W] ? lane_i[l].rem : trial[REM_W-1:0];
      lane_d[l].rem = {nrem[REM_W-2:0], 1'b0};
      lane_d[l].quo = {lane_i[l].quo[QUO_W-2:0], ~trial[REM_W]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

### hdl/tgv_sincos.sv
// Phase to Q1.14 cosine/sine: octant fold, Q30 Horner series, quadrant fix.
module tgv_sincos (
  input  logic                                    clk_i,
  input  logic [tgv_pkg::TRIG_STAGES-1:0]         adv_i,
  input  logic [tgv_pkg::ANGLE_BITS-1:0]          phase_i,
  output logic signed [tgv_pkg::NRM_W-1:0]        cos_o,
  output logic signed [tgv_pkg::NRM_W-1:0]        sin_o
);
  import tgv_pkg::*;

  localparam int unsigned FR_W = ANGLE_BITS - 2;
  localparam int unsigned XP_W = FR_W + 34;

  logic [29:0] x_q    [0:8];
  logic [29:0] x2_q   [1:8];
  logic [1:0]  quad_q [0:9];
  logic        mir_q  [0:9];
  logic [30:0] b_q    [2][4];
  logic [30:0] a_q    [2][1:4];
  logic signed [NRM_W-1:0] cos_q, sin_q;

  // stage 0: fold into first octant, scale to radians in Q30
  logic [FR_W-1:0] frac, ang;
  logic            mir_d;
  logic [XP_W-1:0] xprod;

  always_comb begin
    frac  = phase_i[FR_W-1:0];
    mir_d = frac > FR_W'(1 << (FR_W - 1));
    ang   = mir_d ? FR_W'((1 << FR_W) - int'(frac)) : frac;
    xprod = XP_W'(ang) * XP_W'(PI_HALF_Q32) + XP_W'(1 << (ANGLE_BITS - 1));
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      x_q[0]    <= 30'(xprod >> ANGLE_BITS);
      quad_q[0] <= phase_i[ANGLE_BITS-1 -: 2];
      mir_q[0]  <= mir_d;
    end
  end

  // stage 1: x squared
  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      x2_q[1] <= 30'(mulq30({1'b0, x_q[0]}, {1'b0, x_q[0]}));
    end
  end

  for (genvar k = 1; k <= 9; k++) begin : g_line
    always_ff @(posedge clk_i) begin
      if (adv_i[k]) begin
        quad_q[k] <= quad_q[k-1];
        mir_q[k]  <= mir_q[k-1];
      end
    end
    if (k <= 8) begin : g_x
      always_ff @(posedge clk_i) begin
        if (adv_i[k]) begin
          x_q[k] <= x_q[k-1];
        end
      end
    end
    if (k >= 2 && k <= 8) begin : g_x2
      always_ff @(posedge clk_i) begin
        if (adv_i[k]) begin
          x2_q[k] <= x2_q[k-1];
        end
      end
    end
  end

  // lane 0 sine, lane 1 cosine; each step: divide by constant, then multiply
  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < 4; s++) begin : g_step
      logic [30:0] src, msrc;
      logic [62:0] prod;
      if (s == 0) begin : g_first
        assign src = {1'b0, x2_q[1]};
      end else begin : g_next
        assign src = a_q[l][s];
      end
      if (s == 3 && l == 0) begin : g_byx
        assign msrc = {1'b0, x_q[8]};
      end else begin : g_byx2
        assign msrc = {1'b0, x2_q[2+2*s]};
      end
      assign prod = 63'(src) * 63'(DIV_MAG[l][s]);

      always_ff @(posedge clk_i) begin
        if (adv_i[2+2*s]) begin
          b_q[l][s] <= 31'(prod >> DIV_SH[l][s]);
        end
      end
      always_ff @(posedge clk_i) begin
        if (adv_i[3+2*s]) begin
          a_q[l][s+1] <= mulq30(msrc, Q30_ONE - b_q[l][s]);
        end
      end
    end
  end

  // final stage: round to Q1.14, undo fold, apply quadrant
  logic [30:0] w;
  logic signed [NRM_W-1:0] s14, c14, sf, cf, cos_d, sin_d;

  always_comb begin
    w   = Q30_ONE - (a_q[1][4] >> 1);
    s14 = NRM_W'((32'(a_q[0][4]) + 32'd32768) >> 16);
    c14 = NRM_W'((32'(w) + 32'd32768) >> 16);
    sf  = mir_q[9] ? c14 : s14;
    cf  = mir_q[9] ? s14 : c14;
    case (quad_q[9])
      2'd0:    begin cos_d = cf;  sin_d = sf;  end
      2'd1:    begin cos_d = -sf; sin_d = cf;  end
      2'd2:    begin cos_d = -cf; sin_d = -sf; end
      default: begin cos_d = sf;  sin_d = -cf; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[10]) begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

### hdl/tgv_vertex.sv
// Position and normal products, rounding and saturation; three stages.
module tgv_vertex (
  input  logic                               clk_i,
  input  logic [tgv_pkg::VTX_STAGES-1:0]     adv_i,
  input  logic [tgv_pkg::RAD_W-1:0]          maj_i,
  input  logic [tgv_pkg::RAD_W-1:0]          min_i,
  input  logic signed [tgv_pkg::NRM_W-1:0]   cos_t_i,
  input  logic signed [tgv_pkg::NRM_W-1:0]   sin_t_i,
  input  logic signed [tgv_pkg::NRM_W-1:0]   cos_p_i,
  input  logic signed [tgv_pkg::NRM_W-1:0]   sin_p_i,
  output tgv_pkg::vtx_t                      vtx_o
);
  import tgv_pkg::*;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [47:0] v);
    if (v > 48'sd131071) begin
      return 18'sd131071;
    end else if (v < -48'sd131071) begin
      return -18'sd131071;
    end
    return POS_W'(v);
  endfunction

  // stage A
  logic signed [32:0] rcp;
  logic signed [31:0] ring_d, ring_q;
  logic signed [31:0] nxp_d, nxp_q, nzp_d, nzp_q;
  logic signed [32:0] pyp_d, pyp_q;
  logic signed [NRM_W-1:0] ct_q, st_q, ny_a_q;

  always_comb begin
    rcp    = $signed({1'b0, min_i}) * cos_p_i;
    ring_d = 32'(rcp + $signed({3'b0, maj_i, 14'b0}));
    nxp_d  = cos_p_i * cos_t_i;
    nzp_d  = cos_p_i * sin_t_i;
    pyp_d  = $signed({1'b0, min_i}) * sin_p_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      ring_q <= ring_d;
      nxp_q  <= nxp_d;
      nzp_q  <= nzp_d;
      pyp_q  <= pyp_d;
      ct_q   <= cos_t_i;
      st_q   <= sin_t_i;
      ny_a_q <= sin_p_i;
    end
  end

  // stage B
  logic signed [47:0] pxp_q, pzp_q, pyw, pyr;
  logic signed [31:0] nxr, nzr;
  logic signed [POS_W-1:0] py_b_q;
  logic signed [NRM_W-1:0] nx_b_q, ny_b_q, nz_b_q;

  always_comb begin
    pyw = pyp_q;
    pyr = (pyw + 48'sd8192) >>> 14;
    nxr = (nxp_q + 32'sd8192) >>> 14;
    nzr = (nzp_q + 32'sd8192) >>> 14;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      pxp_q  <= ring_q * ct_q;
      pzp_q  <= ring_q * st_q;
      py_b_q <= sat_pos(pyr);
      nx_b_q <= NRM_W'(nxr);
      nz_b_q <= NRM_W'(nzr);
      ny_b_q <= ny_a_q;
    end
  end

  // stage C
  logic signed [47:0] pxr, pzr;
  vtx_t vtx_q;

  always_comb begin
    pxr = (pxp_q + 48'sd134217728) >>> 28;
    pzr = (pzp_q + 48'sd134217728) >>> 28;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[2]) begin
      vtx_q.pos_x  <= sat_pos(pxr);
      vtx_q.pos_y  <= py_b_q;
      vtx_q.pos_z  <= sat_pos(pzr);
      vtx_q.norm_x <= nx_b_q;
      vtx_q.norm_y <= ny_b_q;
      vtx_q.norm_z <= nz_b_q;
    end
  end

  assign vtx_o = vtx_q;

endmodule

### hdl/torus_grid_vertex_generator.sv
// Torus grid vertex generator. Each beat on in_i carries a grid point (ring_step i,
// tube_step j); each beat on out_o carries its vertex: Q9.8 position, Q1.14 normal,
// Q1.16 texture coordinates, mesh indices and the quad/valid flags. Points with
// i > M or j > N come out with every field zero. The block is a 32-stage pipeline
// and takes one point per clock while out_o is not stalled. Stage 0 registers the
// point, 17 identical divider cells then produce one bit each of round(i*65536/M)
// and round(j*65536/N), 11 stages evaluate sine and cosine of both angles, and 3
// stages form the products. Every stage has its own valid bit and moves when the
// stage after it is empty or moving, so a stall at out_o fills the bubbles first and
// in_i keeps accepting until the whole pipe is full. Register writes on cfg_i take
// effect at once and must only be issued while the pipe is empty; counts of 0 act as
// 1 and counts above 256 act as 256.
`include "torus_grid_vertex_generator_defines.svh"

module torus_grid_vertex_generator (
  input  logic      clk_i,
  input  logic      rst_ni,
  tgv_cfg_if.sink   cfg_i,
  tgv_in_if.sink    in_i,
  tgv_out_if.source out_o
);
  import tgv_pkg::*;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    if (c == '0) begin
      return CNT_W'(1);
    end else if (c > CNT_W'(MAX_SEGMENTS)) begin
      return CNT_W'(MAX_SEGMENTS);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- config
  logic [RAD_W-1:0] major_radius_q, minor_radius_q;
  logic [CNT_W-1:0] major_count_q, minor_count_q;
  logic [CNT_W-1:0] m_eff, n_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_radius_q <= MAJOR_RADIUS_RST;
      minor_radius_q <= MINOR_RADIUS_RST;
      major_count_q  <= MAJOR_COUNT_RST;
      minor_count_q  <= MINOR_COUNT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_MAJOR_RADIUS: major_radius_q <= cfg_i.data;
        CFG_MINOR_RADIUS: minor_radius_q <= cfg_i.data;
        CFG_MAJOR_COUNT:  major_count_q  <= cfg_i.data[CNT_W-1:0];
        CFG_MINOR_COUNT:  minor_count_q  <= cfg_i.data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign m_eff = eff_count(major_count_q);
  assign n_eff = eff_count(minor_count_q);

  // ------------------------------------------------------ stage flow control
  // adv[k]: stage k loads this cycle. A stage loads when empty or draining.
  logic [N_STAGES:0]   adv;
  logic [N_STAGES-1:0] v_d, v_q;

  always_comb begin
    adv[N_STAGES] = out_o.ready;
    for (int k = N_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
    v_d[0] = adv[0] ? in_i.valid : v_q[0];
    for (int k = 1; k < N_STAGES; k++) begin
      v_d[k] = adv[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = adv[0];

  // ------------------------------------------------------------ entry stage
  logic [CNT_W:0]  n_step;
  side_t           side_d;
  side_t           side_q [N_STAGES];
  div_lane_t [1:0] dl [0:DIV_CELLS];
  div_lane_t [1:0] lane_d;

  always_comb begin
    n_step      = {1'b0, n_eff} + (CNT_W+1)'(1);
    side_d.ok   = (in_i.ring_step <= m_eff) && (in_i.tube_step <= n_eff);
    side_d.qs   = (in_i.ring_step < m_eff) && (in_i.tube_step < n_eff);
    side_d.vi   = IDX_W'(in_i.ring_step) * IDX_W'(n_step) + IDX_W'(in_i.tube_step);
    side_d.rbi  = side_d.vi + IDX_W'(n_step);
    side_d.tu   = '0;
    side_d.tv   = '0;
    // dividend i*2^16 + M/2 gives round-half-up quotient
    lane_d[0].rem = {in_i.ring_step, {ANGLE_BITS{1'b0}}} + REM_W'(m_eff >> 1);
    lane_d[0].quo = '0;
    lane_d[1].rem = {in_i.tube_step, {ANGLE_BITS{1'b0}}} + REM_W'(n_eff >> 1);
    lane_d[1].quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dl[0]     <= lane_d;
      side_q[0] <= side_d;
    end
  end

  // sideband shift line; texture coordinates join when the divide finishes
  for (genvar k = 1; k < N_STAGES; k++) begin : g_side
    if (k == ST_TRIG) begin : g_join
      side_t joined;
      always_comb begin
        joined    = side_q[k-1];
        joined.tu = dl[DIV_CELLS][0].quo;
        joined.tv = dl[DIV_CELLS][1].quo;
      end
      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          side_q[k] <= joined;
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk_i) begin
        if (adv[k]) begin
          side_q[k] <= side_q[k-1];
        end
      end
    end
  end

  // ----------------------------------------------------------- divider row
  logic [1:0][CNT_W-1:0] dvs;
  assign dvs = {n_eff, m_eff};

  for (genvar c = 0; c < DIV_CELLS; c++) begin : g_cell
    tgv_div_cell u_cell (
      .clk_i  (clk_i),
      .adv_i  (adv[1+c]),
      .dvs_i  (dvs),
      .lane_i (dl[c]),
      .lane_o (dl[c+1])
    );
  end

  // ------------------------------------------------------------ trig units
  logic signed [NRM_W-1:0] cos_t, sin_t, cos_p, sin_p;

  tgv_sincos u_theta (
    .clk_i   (clk_i),
    .adv_i   (adv[ST_TRIG +: TRIG_STAGES]),
    .phase_i (dl[DIV_CELLS][0].quo[ANGLE_BITS-1:0]),
    .cos_o   (cos_t),
    .sin_o   (sin_t)
  );

  tgv_sincos u_phi (
    .clk_i   (clk_i),
    .adv_i   (adv[ST_TRIG +: TRIG_STAGES]),
    .phase_i (dl[DIV_CELLS][1].quo[ANGLE_BITS-1:0]),
    .cos_o   (cos_p),
    .sin_o   (sin_p)
  );

  // --------------------------------------------------------- vertex math
  vtx_t vtx;

  tgv_vertex u_vertex (
    .clk_i   (clk_i),
    .adv_i   (adv[ST_VTX +: VTX_STAGES]),
    .maj_i   (major_radius_q),
    .min_i   (minor_radius_q),
    .cos_t_i (cos_t),
    .sin_t_i (sin_t),
    .cos_p_i (cos_p),
    .sin_p_i (sin_p),
    .vtx_o   (vtx)
  );

  // --------------------------------------------------------------- output
  side_t so;
  assign so = side_q[N_STAGES-1];

  assign out_o.valid           = v_q[N_STAGES-1];
  assign out_o.pos_x           = so.ok ? vtx.pos_x  : '0;
  assign out_o.pos_y           = so.ok ? vtx.pos_y  : '0;
  assign out_o.pos_z           = so.ok ? vtx.pos_z  : '0;
  assign out_o.norm_x          = so.ok ? vtx.norm_x : '0;
  assign out_o.norm_y          = so.ok ? vtx.norm_y : '0;
  assign out_o.norm_z          = so.ok ? vtx.norm_z : '0;
  assign out_o.tex_u           = so.ok ? so.tu      : '0;
  assign out_o.tex_v           = so.ok ? so.tv      : '0;
  assign out_o.vertex_index    = so.ok ? so.vi      : '0;
  assign out_o.row_below_index = so.ok ? so.rbi     : '0;
  assign out_o.quad_start      = so.ok && so.qs;
  assign out_o.point_valid     = so.ok;

  // ----------------------------------------------------------- assertions
  logic [IDX_W-1:0] row_gap;
  assign row_gap = out_o.row_below_index - out_o.vertex_index;

  `TGV_ASSERT(a_quad_in_grid, out_o.valid && out_o.quad_start |-> out_o.point_valid, "quad")
  `TGV_ASSERT(a_row_step, out_o.valid && out_o.point_valid |-> row_gap == IDX_W'(n_step), "row")
  `TGV_ASSERT(a_entry_fill, in_i.valid && in_i.ready |=> v_q[0], "entry stage empty")
  `TGV_ASSERT_ALWAYS(a_stall_full, !adv[0] |-> (&v_q), "stall with bubble")

endmodule
